### hw/rtl/sfm_pkg.sv
// Shared types, codes and constants of the SPI frame master.
package sfm_pkg;

    localparam int SFM_MAX_BYTES   = 32;
    localparam int SFM_CNT_W       = 6;
    localparam int SFM_HDR_W       = 24;
    localparam int SFM_BITCNT_W    = 5;
    localparam int SFM_IN_TDATA_W  = 40;
    localparam int SFM_OUT_TDATA_W = 16;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [SFM_BITCNT_W-1:0] HDR_LAST_BIT  = 5'd23;
    localparam logic [SFM_BITCNT_W-1:0] BYTE_LAST_BIT = 5'd7;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DATA
    } sfm_phase_t;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_LOAD,
        KIND_TICK
    } sfm_kind_t;

    // One classified request as it waits in the queue
    typedef struct packed {
        logic                 op_en;
        sfm_kind_t            kind;
        logic [SFM_HDR_W-1:0] header;
        logic [SFM_CNT_W-1:0] count;
        logic                 wr;
        logic [7:0]           tx_byte;
        logic                 miso;
    } sfm_cmd_t;

    // One result of a request
    typedef struct packed {
        logic       sclk;
        logic       mosi;
        logic       chip_select_n;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       need_byte;
        logic       frame_done;
        logic       busy;
    } sfm_res_t;

endpackage

### hw/rtl/sfm_front.sv
// Front end: decode and classify an incoming request, build header and clamp count.
module sfm_front #(
    parameter int MAX_BYTES = sfm_pkg::SFM_MAX_BYTES
) (
    input  logic [1:0]                         mode,
    input  logic [sfm_pkg::SFM_IN_TDATA_W-1:0] data,
    output sfm_pkg::sfm_cmd_t                  cmd
);
    import sfm_pkg::*;

    logic [15:0]          address;
    logic [4:0]           block_select;
    logic                 write_flag;
    logic [SFM_CNT_W-1:0] byte_count;
    logic [SFM_CNT_W-1:0] count_clamped;

    assign address      = data[15:0];
    assign block_select = data[20:16];
    assign write_flag   = data[21];
    assign byte_count   = data[27:22];

    // Clamp the count to the largest frame the block allows
    always_comb
    begin
        if ({1'b0, byte_count} > (SFM_CNT_W+1)'(MAX_BYTES))
            count_clamped = SFM_CNT_W'(MAX_BYTES);
        else
            count_clamped = byte_count;
    end

    always_comb
    begin
        cmd.op_en   = 1'b1;
        cmd.kind    = KIND_TICK;
        cmd.header  = {address, block_select, write_flag, 2'b00};
        cmd.count   = count_clamped;
        cmd.wr      = write_flag;
        cmd.tx_byte = data[35:28];
        cmd.miso    = data[36];
        case (mode)
            MODE_START: cmd.kind = KIND_START;
            MODE_LOAD:  cmd.kind = KIND_LOAD;
            MODE_TICK:  cmd.kind = KIND_TICK;
            default:    cmd.op_en = 1'b0;
        endcase
    end

endmodule

### hw/rtl/sfm_queue.sv
// Two-entry request queue between front and back end.
module sfm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfm_pkg::sfm_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output sfm_pkg::sfm_cmd_t head_cmd
);
    import sfm_pkg::*;

    sfm_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### hw/rtl/sfm_back.sv
// Back end: frame sequencer, serial line state and result register.
module sfm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  sfm_pkg::sfm_cmd_t cmd,
    output logic              cmd_take,
    output logic              res_valid,
    input  logic              res_ready,
    output sfm_pkg::sfm_res_t res
);
    import sfm_pkg::*;

    sfm_phase_t              phase_reg,      phase_next;
    logic [SFM_HDR_W-1:0]    header_reg,     header_next;
    logic [SFM_BITCNT_W-1:0] bit_cnt_reg,    bit_cnt_next;
    logic [SFM_CNT_W-1:0]    bytes_left_reg, bytes_left_next;
    logic                    clk_level_reg,  clk_level_next;
    logic                    is_write_reg,   is_write_next;
    logic [7:0]              data_shift_reg, data_shift_next;
    logic [7:0]              pend_byte_reg,  pend_byte_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    mosi_reg,       mosi_next;
    logic                    res_valid_reg;
    sfm_res_t                res_reg,        res_next;

    logic       rxv;
    logic [7:0] rxb;
    logic       done;
    logic       begin_ok;
    logic [2:0] wr_index;
    logic       boundary;

    assign cmd_take  = cmd_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign begin_ok  = !is_write_reg || pend_valid_reg;
    assign wr_index  = 3'd6 - bit_cnt_reg[2:0];

    // Next state of the frame sequencer
    always_comb
    begin
        phase_next      = phase_reg;
        header_next     = header_reg;
        bit_cnt_next    = bit_cnt_reg;
        bytes_left_next = bytes_left_reg;
        clk_level_next  = clk_level_reg;
        is_write_next   = is_write_reg;
        data_shift_next = data_shift_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        mosi_next       = mosi_reg;
        rxv             = 1'b0;
        rxb             = 8'd0;
        done            = 1'b0;
        if (cmd.op_en)
        begin
            case (cmd.kind)
                KIND_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        is_write_next   = cmd.wr;
                        header_next     = cmd.header;
                        bytes_left_next = cmd.count;
                        bit_cnt_next    = '0;
                        clk_level_next  = 1'b0;
                        phase_next      = PH_HEADER;
                        mosi_next       = cmd.header[SFM_HDR_W-1];
                    end
                end
                KIND_LOAD:
                begin
                    pend_byte_next  = cmd.tx_byte;
                    pend_valid_next = 1'b1;
                end
                KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (!clk_level_reg)
                            clk_level_next = 1'b1;
                        else if ((phase_reg == PH_HEADER && bit_cnt_reg < HDR_LAST_BIT)
                                 || (phase_reg == PH_DATA && bit_cnt_reg < BYTE_LAST_BIT))
                        begin
                            // Advance one bit within header or byte
                            bit_cnt_next   = bit_cnt_reg + 1'b1;
                            clk_level_next = 1'b0;
                            if (phase_reg == PH_HEADER)
                            begin
                                header_next = {header_reg[SFM_HDR_W-2:0], 1'b0};
                                mosi_next   = header_reg[SFM_HDR_W-2];
                            end
                            else if (is_write_reg)
                                mosi_next = data_shift_reg[wr_index];
                            else
                            begin
                                data_shift_next = {data_shift_reg[6:0], cmd.miso};
                                if (bit_cnt_reg == BYTE_LAST_BIT - 1'b1)
                                begin
                                    rxv = 1'b1;
                                    rxb = data_shift_next;
                                end
                            end
                        end
                        else if ((phase_reg == PH_HEADER && bytes_left_reg == '0)
                                 || (phase_reg == PH_DATA && bytes_left_reg <= 1))
                        begin
                            // Close the frame
                            phase_next      = PH_IDLE;
                            clk_level_next  = 1'b0;
                            bit_cnt_next    = '0;
                            bytes_left_next = '0;
                            done            = 1'b1;
                        end
                        else if (begin_ok)
                        begin
                            // Start a data byte; hold the clock high if none is pending
                            if (is_write_reg)
                            begin
                                data_shift_next = pend_byte_reg;
                                pend_valid_next = 1'b0;
                                mosi_next       = pend_byte_reg[7];
                            end
                            else
                                data_shift_next = {data_shift_reg[6:0], cmd.miso};
                            phase_next     = PH_DATA;
                            bit_cnt_next   = '0;
                            clk_level_next = 1'b0;
                            if (phase_reg == PH_DATA)
                                bytes_left_next = bytes_left_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result fields from the state left by this request
    always_comb
    begin
        case (phase_next)
            PH_HEADER: boundary = (bit_cnt_next >= HDR_LAST_BIT) && (bytes_left_next != '0);
            PH_DATA:   boundary = (bit_cnt_next >= BYTE_LAST_BIT) && (bytes_left_next > 1);
            default:   boundary = 1'b0;
        endcase
        res_next.sclk          = clk_level_next;
        res_next.mosi          = mosi_next;
        res_next.chip_select_n = (phase_next == PH_IDLE);
        res_next.rx_valid      = rxv;
        res_next.rx_byte       = rxb;
        res_next.need_byte     = is_write_next && clk_level_next && !pend_valid_next
                                 && boundary;
        res_next.frame_done    = done;
        res_next.busy          = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            header_reg     <= '0;
            bit_cnt_reg    <= '0;
            bytes_left_reg <= '0;
            clk_level_reg  <= 1'b0;
            is_write_reg   <= 1'b0;
            data_shift_reg <= '0;
            pend_valid_reg <= 1'b0;
            mosi_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                phase_reg      <= phase_next;
                header_reg     <= header_next;
                bit_cnt_reg    <= bit_cnt_next;
                bytes_left_reg <= bytes_left_next;
                clk_level_reg  <= clk_level_next;
                is_write_reg   <= is_write_next;
                data_shift_reg <= data_shift_next;
                pend_valid_reg <= pend_valid_next;
                mosi_reg       <= mosi_next;
                res_valid_reg  <= 1'b1;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            pend_byte_reg <= pend_byte_next;
            res_reg       <= res_next;
        end
    end

endmodule

### hw/rtl/spi_frame_master.sv
// Top level of the SPI frame master: front end, request queue and back end.
//
//  channel  | direction | tdata / tuser / tlast
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | frame fields and write byte / mode / -
//  m_axis   | out       | line levels and status / rx_valid / frame_done
//
// One request per cycle is taken while the queue has room, and one result per
// request is given; a request waits in a queue entry, then its result is loaded
// into the result register by the sequencer, which settles each request as taken.
// Reset clears the queue, the sequencer and the result valid flag; the pending
// write byte and the result fields hold no reset value.
// When m_axis_tready stays low the result register holds, the queue fills with
// two requests and s_axis_tready then drops until the result is taken.
module spi_frame_master #(
    parameter int MAX_BYTES = sfm_pkg::SFM_MAX_BYTES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] address, [20:16] block_select, [21] write_flag, [27:22] byte_count,
    // [35:28] tx_byte, [36] miso, [39:37] zero
    input  logic [sfm_pkg::SFM_IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] sclk, [1] mosi, [2] chip_select_n, [10:3] rx_byte, [11] need_byte,
    // [12] busy_res, [15:13] zero
    output logic [sfm_pkg::SFM_OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] rx_valid
    output logic [0:0]                           m_axis_tuser,
    // frame_done
    output logic                                 m_axis_tlast
);
    import sfm_pkg::*;

    sfm_cmd_t front_cmd;
    sfm_cmd_t head_cmd;
    sfm_res_t res;
    logic     q_full;
    logic     q_not_empty;
    logic     q_pop;
    logic     q_push;

    // Accept a request whenever the queue has room
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    sfm_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .mode (s_axis_tuser),
        .data (s_axis_tdata),
        .cmd  (front_cmd)
    );

    sfm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    sfm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_take  (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result fields onto the output bus
    assign m_axis_tdata = {3'b000, res.busy, res.need_byte, res.rx_byte,
                           res.chip_select_n, res.mosi, res.sclk};
    assign m_axis_tuser = res.rx_valid;
    assign m_axis_tlast = res.frame_done;

endmodule

### hw/rtl/sfm_checker.sv
// Port-level checks of the SPI frame master and their binding to the top level.
module sfm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [sfm_pkg::SFM_OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                          m_axis_tuser,
    input logic                                m_axis_tlast
);
    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Chip select is the inverse of busy
    a_cs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2] != m_axis_tdata[12])
        else $error("chip select and busy disagree");

    // A frame end leaves the lines idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2] && !m_axis_tdata[0]
            && !m_axis_tdata[12] && !m_axis_tdata[11])
        else $error("frame end with lines not idle");

    // A read byte completes only inside a frame with the clock low
    a_rx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[12] && !m_axis_tdata[0]
            && !m_axis_tlast)
        else $error("read byte outside a frame");

    // A missing write byte holds the clock high inside a frame
    a_need_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[0] && m_axis_tdata[12])
        else $error("write byte request without held clock");

endmodule

bind spi_frame_master sfm_checker u_sfm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
